>>> rtl/core/crcpc_pkg.sv
// Shared types, constants and the CRC-32C byte update for the packet header checker.
`timescale 1ns / 1ps

package crcpc_pkg;

    localparam int MAX_PAYLOAD_BYTES = 264;
    localparam int HEADER_BYTES      = 10;

    // Byte counter saturates one past the longest accepted packet.
    localparam int POS_LIMIT = HEADER_BYTES + MAX_PAYLOAD_BYTES;
    localparam int POS_W     = $clog2(POS_LIMIT + 2);
    localparam int CMP_W     = (POS_W > 10) ? POS_W : 10;

    localparam int LEN_W       = 9;
    localparam int LEN_SAT     = 511;
    localparam int TOO_LONG_LEN = (MAX_PAYLOAD_BYTES > LEN_SAT) ? LEN_SAT : MAX_PAYLOAD_BYTES;

    // Header byte offsets
    localparam int POS_HDR_TYPE = 1;
    localparam int POS_SRC_ADDR = 2;
    localparam int POS_DST_ADDR = 3;
    localparam int POS_SRC_PORT = 4;
    localparam int POS_DST_PORT = 5;
    localparam int POS_CRC_LO   = 6;
    localparam int POS_CRC_HI   = 9;

    localparam logic [1:0]  TYPE_CSP        = 2'h1;
    localparam logic [7:0]  BCAST_ADDR      = 8'd255;
    localparam logic [7:0]  DEV_HIGH_LIMIT  = 8'd254;
    localparam logic [7:0]  DPORT_HIGH_OFS  = 8'd126;
    localparam logic [8:0]  DPORT_OFS       = 9'd130;
    localparam logic [8:0]  DPORT_CSP_ADJ   = 9'd100;

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // Table entries of the reflected CRC-32C for single-bit byte values, bit 0 first.
    localparam logic [31:0] CRC_BIT_TAB [8] = '{
        32'hF26B_8303, 32'hE13B_70F7, 32'hC79A_971F, 32'h8AD9_58CF,
        32'h105E_C76F, 32'h20BD_8EDE, 32'h417B_1DBC, 32'h82F6_3B78
    };

    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    localparam int CFG_ADDR_W = 4;
    localparam logic [1:0] REG_DEVICE_ADDRESS  = 2'd0;
    localparam logic [1:0] REG_HUB_ADDRESS     = 2'd1;
    localparam logic [1:0] REG_EXPECTED_SPORT  = 2'd2;

    typedef enum logic [3:0] {
        ST_OK       = 4'd0,
        ST_SHORT    = 4'd1,
        ST_BCAST    = 4'd2,
        ST_DST_ADDR = 4'd3,
        ST_SRC_ADDR = 4'd4,
        ST_DST_PORT = 4'd5,
        ST_SRC_PORT = 4'd6,
        ST_CRC      = 4'd7,
        ST_TOO_LONG = 4'd8
    } status_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } kind_t;

    typedef struct packed {
        logic [7:0]        device_address;
        logic [7:0]        hub_address;
        logic signed [8:0] expected_source_port;
    } cfg_t;

    typedef struct packed {
        kind_t             item_kind;
        logic [7:0]        payload_byte;
        status_t           status;
        logic [LEN_W-1:0]  payload_length;
        logic              end_of_run;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } push_t;

    // One byte of reflected CRC-32C: table lookup built from the eight single-bit entries.
    function automatic logic [31:0] crc32c_byte(input logic [31:0] c, input logic [7:0] b);
        logic [7:0]  x;
        logic [31:0] t;
        x = c[7:0] ^ b;
        t = '0;
        for (int j = 0; j < 8; j++) begin
            if (x[j]) begin
                t = t ^ CRC_BIT_TAB[j];
            end
        end
        return (c >> 8) ^ t;
    endfunction

endpackage

>>> rtl/core/crc32c_packet_header_checker.sv
// Top level: packet header and CRC-32C checker with stream ports and APB registers.
// Results are registered in the four-entry result queue and offered from its head.
// One byte per cycle while s_tready is high; a last payload byte yields two results.
// s_tready drops while the four-entry result queue has fewer than two free slots.
// Reset (aresetn, synchronous, active low) resets packet state, queue and registers.
`timescale 1ns / 1ps

module crc32c_packet_header_checker
    import crcpc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] data_byte
    input  logic                  s_tlast,   // last_byte
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,   // [7:0] payload_byte, [11:8] status,
                                             // [20:12] payload_length, [23:21] zero
    output logic [0:0]            m_tuser,   // [0] item_kind
    output logic                  m_tlast,   // end_of_run
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    cfg_t    cfg;
    push_t   push;
    logic    room;
    logic    accept;
    result_t res;

    assign s_tready = room;
    assign accept   = s_tvalid & s_tready;

    crcpc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    crcpc_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .cfg       (cfg),
        .push      (push)
    );

    crcpc_outq u_outq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (room),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_res   (res)
    );

    assign m_tdata = {3'b000, res.payload_length, res.status, res.payload_byte};
    assign m_tuser = res.item_kind;
    assign m_tlast = res.end_of_run;

endmodule

>>> rtl/core/crcpc_cfg.sv
// APB register block for the device address, hub address and expected source port.
`timescale 1ns / 1ps

module crcpc_cfg
    import crcpc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_sel = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.device_address       <= 8'd0;
            cfg_reg.hub_address          <= 8'd0;
            cfg_reg.expected_source_port <= -9'sd1;
        end else if (wr_en) begin
            case (reg_sel)
                REG_DEVICE_ADDRESS: cfg_reg.device_address       <= pwdata[7:0];
                REG_HUB_ADDRESS:    cfg_reg.hub_address          <= pwdata[7:0];
                REG_EXPECTED_SPORT: cfg_reg.expected_source_port <= $signed(pwdata[8:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_DEVICE_ADDRESS: prdata = {24'd0, cfg_reg.device_address};
            REG_HUB_ADDRESS:    prdata = {24'd0, cfg_reg.hub_address};
            REG_EXPECTED_SPORT: prdata = 32'(cfg_reg.expected_source_port);
            default:            prdata = 32'd0;
        endcase
    end

endmodule

>>> rtl/core/crcpc_parser.sv
// Per-byte header checks, CRC update and result generation for one packet at a time.
`timescale 1ns / 1ps

module crcpc_parser
    import crcpc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  cfg_t       cfg,
    output push_t      push
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [31:0]      crc_reg, crc_next;
    logic [31:0]      rcv_reg, rcv_next;
    status_t          fault_reg, fault_next;
    logic             csp_reg, csp_next;

    logic             full;
    logic             hit;
    status_t          code;
    logic [1:0]       crc_lane;
    logic [8:0]       dport_want;
    logic [POS_W-1:0] pay_cnt;
    logic [CMP_W-1:0] pay_cnt_ext;
    result_t          pay_res;
    result_t          stat_res;
    logic             pay_vld;

    assign full     = pos_reg >= POS_W'(POS_LIMIT);
    assign crc_lane = 2'(pos_reg - POS_W'(POS_CRC_LO));

    always_comb begin
        if (cfg.device_address >= DEV_HIGH_LIMIT) begin
            dport_want = {1'b0, cfg.device_address - DPORT_HIGH_OFS};
        end else begin
            dport_want = {1'b0, cfg.device_address} + DPORT_OFS
                         - (csp_reg ? DPORT_CSP_ADJ : 9'd0);
        end
    end

    // Header checks and state update for the byte in hand
    always_comb begin
        pos_next   = pos_reg;
        crc_next   = crc_reg;
        rcv_next   = rcv_reg;
        fault_next = fault_reg;
        csp_next   = csp_reg;
        hit        = 1'b0;
        code       = ST_OK;
        pay_vld    = 1'b0;

        if (full) begin
            pos_next = POS_W'(POS_LIMIT + 1);
        end else begin
            pos_next = pos_reg + POS_W'(1);
            if (pos_reg == POS_W'(POS_HDR_TYPE)) begin
                csp_next = (data_byte[7:6] == TYPE_CSP);
            end else if (pos_reg == POS_W'(POS_SRC_ADDR)) begin
                hit  = data_byte != cfg.device_address;
                code = ST_SRC_ADDR;
            end else if (pos_reg == POS_W'(POS_DST_ADDR)) begin
                hit  = data_byte != cfg.hub_address;
                code = (data_byte == BCAST_ADDR) ? ST_BCAST : ST_DST_ADDR;
            end else if (pos_reg == POS_W'(POS_SRC_PORT)) begin
                hit  = {1'b0, data_byte} != cfg.expected_source_port;
                code = ST_SRC_PORT;
            end else if (pos_reg == POS_W'(POS_DST_PORT)) begin
                hit  = {1'b0, data_byte} != dport_want;
                code = ST_DST_PORT;
            end else if (pos_reg >= POS_W'(POS_CRC_LO) && pos_reg <= POS_W'(POS_CRC_HI)) begin
                rcv_next = rcv_reg | (32'(data_byte) << {crc_lane, 3'b000});
            end

            // Keep the highest-ranking fault, which is the lowest code
            if (hit && (fault_reg == ST_OK || code < fault_reg)) begin
                fault_next = code;
            end

            if ((pos_reg >= POS_W'(POS_SRC_ADDR) && pos_reg <= POS_W'(POS_DST_PORT))
                || pos_reg >= POS_W'(HEADER_BYTES)) begin
                crc_next = crc32c_byte(crc_reg, data_byte);
            end

            pay_vld = pos_reg >= POS_W'(HEADER_BYTES);
        end
    end

    assign pay_cnt     = pos_next - POS_W'(HEADER_BYTES);
    assign pay_cnt_ext = CMP_W'(pay_cnt);

    always_comb begin
        pay_res                = '0;
        pay_res.item_kind      = KIND_PAYLOAD;
        pay_res.payload_byte   = data_byte;
        pay_res.status         = ST_OK;

        stat_res               = '0;
        stat_res.item_kind     = KIND_STATUS;
        stat_res.end_of_run    = 1'b1;
        if (pos_next > POS_W'(POS_LIMIT)) begin
            stat_res.status         = ST_TOO_LONG;
            stat_res.payload_length = LEN_W'(TOO_LONG_LEN);
        end else if (pos_next < POS_W'(HEADER_BYTES)) begin
            stat_res.status         = ST_SHORT;
            stat_res.payload_length = '0;
        end else begin
            stat_res.payload_length = (pay_cnt_ext > CMP_W'(LEN_SAT)) ? LEN_W'(LEN_SAT)
                                                                      : pay_cnt_ext[LEN_W-1:0];
            if (fault_next != ST_OK) begin
                stat_res.status = fault_next;
            end else if ((crc_next ^ CRC_INIT) != rcv_next) begin
                stat_res.status = ST_CRC;
            end else begin
                stat_res.status = ST_OK;
            end
        end
    end

    // Payload item goes first, the status item after it
    always_comb begin
        push.count = 2'd0;
        push.r0    = pay_vld ? pay_res : stat_res;
        push.r1    = stat_res;
        if (accept) begin
            push.count = 2'(pay_vld) + 2'(last_byte);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            crc_reg   <= CRC_INIT;
            rcv_reg   <= '0;
            fault_reg <= ST_OK;
            csp_reg   <= 1'b0;
        end else if (accept) begin
            if (last_byte) begin
                pos_reg   <= '0;
                crc_reg   <= CRC_INIT;
                rcv_reg   <= '0;
                fault_reg <= ST_OK;
                csp_reg   <= 1'b0;
            end else begin
                pos_reg   <= pos_next;
                crc_reg   <= crc_next;
                rcv_reg   <= rcv_next;
                fault_reg <= fault_next;
                csp_reg   <= csp_next;
            end
        end
    end

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && last_byte |=> pos_reg == '0 && fault_reg == ST_OK && crc_reg == CRC_INIT)
        else $error("packet state not cleared after last item");

    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_W'(POS_LIMIT + 1))
        else $error("byte position beyond saturation");

    a_status_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && last_byte |-> push.count != 2'd0)
        else $error("last item produced no status");

    a_payload_in_body: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && pos_reg < POS_W'(HEADER_BYTES) |-> push.count == 2'(last_byte))
        else $error("header item forwarded as payload");

endmodule

>>> rtl/core/crcpc_outq.sv
// Small result queue that takes up to two items per cycle and hands out one.
`timescale 1ns / 1ps

module crcpc_outq
    import crcpc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  push_t   push,
    output logic    room,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_res
);

    result_t               mem_reg [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OUTQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OUTQ_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  pop;
    logic [OUTQ_PTR_W-1:0] wr_ptr_inc;

    assign room    = cnt_reg <= OUTQ_CNT_W'(OUTQ_DEPTH - 2);
    assign m_valid = cnt_reg != '0;
    assign m_res   = mem_reg[rd_ptr_reg];
    assign pop     = m_valid & m_ready;

    assign wr_ptr_inc  = wr_ptr_reg + OUTQ_PTR_W'(1);
    assign wr_ptr_next = wr_ptr_reg + OUTQ_PTR_W'(push.count);
    assign rd_ptr_next = rd_ptr_reg + OUTQ_PTR_W'(pop);
    assign cnt_next    = cnt_reg + OUTQ_CNT_W'(push.count) - OUTQ_CNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.count == 2'd2) begin
            mem_reg[wr_ptr_inc] <= push.r1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= OUTQ_CNT_W'(OUTQ_DEPTH))
        else $error("result queue overflow");

    a_push_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push.count != 2'd0 |-> $past(room) || !$past(aresetn) || room)
        else $error("push into full result queue");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        OUTQ_PTR_W'(wr_ptr_reg - rd_ptr_reg) == OUTQ_PTR_W'(cnt_reg))
        else $error("queue pointers disagree with fill count");

endmodule

>>> tb/sv/crc32c_packet_header_checker_test.sv
// Self-checking bench: packet header and CRC-32C checker against a byte-level predictor.
`timescale 1ns / 1ps

module crc32c_packet_header_checker_test;
    import crcpc_pkg::*;

    localparam logic [31:0] CRC32C_POLY   = 32'h82F6_3B78;
    localparam logic [1:0]  REG_UNUSED    = 2'd3;
    localparam int          RANDOM_BYTES  = 1200;
    localparam int          SETTLE_CYCLES = 4;
    localparam int          DIRECTED_ROWS = 19;

    typedef enum int {
        INJ_NONE, INJ_BCAST, INJ_DST, INJ_SRC, INJ_SPORT, INJ_DPORT, INJ_CRC, INJ_MULTI
    } inj_e;

    typedef logic [7:0] byte_q_t [$];

    // One directed packet; typed rows carry the status item read straight off the rules.
    typedef struct packed {
        int      phase;
        inj_e    inj;
        int      plen;
        int      cut;
        bit      csp;
        bit      typed;
        status_t st;
        int      len;
    } pkt_row_t;

    localparam pkt_row_t DIRECTED [DIRECTED_ROWS] = '{
        // after reset: dev 0, hub 0, source port unset
        '{0, INJ_NONE,  0,   1, 1'b0, 1'b1, ST_SHORT,    0},
        '{0, INJ_NONE,  5,   9, 1'b0, 1'b1, ST_SHORT,    0},
        '{0, INJ_NONE,  0,   0, 1'b0, 1'b1, ST_SRC_PORT, 0},
        '{0, INJ_BCAST, 2,   0, 1'b1, 1'b1, ST_BCAST,    2},
        '{0, INJ_NONE,  264, 0, 1'b0, 1'b1, ST_SRC_PORT, 264},
        '{0, INJ_NONE,  265, 0, 1'b0, 1'b1, ST_TOO_LONG, 264},
        // dev 254, hub 255, source port 254
        '{1, INJ_NONE,  0,   0, 1'b0, 1'b1, ST_OK,       0},
        '{1, INJ_NONE,  3,   0, 1'b1, 1'b0, ST_OK,       0},
        '{1, INJ_SRC,   1,   0, 1'b0, 1'b1, ST_SRC_ADDR, 1},
        '{1, INJ_DST,   1,   0, 1'b0, 1'b1, ST_DST_ADDR, 1},
        '{1, INJ_SPORT, 1,   0, 1'b1, 1'b1, ST_SRC_PORT, 1},
        '{1, INJ_DPORT, 1,   0, 1'b0, 1'b1, ST_DST_PORT, 1},
        '{1, INJ_CRC,   4,   0, 1'b0, 1'b1, ST_CRC,      4},
        '{1, INJ_MULTI, 2,   0, 1'b1, 1'b0, ST_OK,       0},
        // dev 255, hub 0, source port 0
        '{2, INJ_NONE,  1,   0, 1'b1, 1'b1, ST_OK,       1},
        '{2, INJ_BCAST, 0,   0, 1'b0, 1'b1, ST_BCAST,    0},
        '{2, INJ_DST,   0,   0, 1'b0, 1'b0, ST_OK,       0},
        // dev 130: only a CSP type can match the destination port
        '{3, INJ_NONE,  2,   0, 1'b0, 1'b1, ST_OK,       2},
        '{3, INJ_DPORT, 2,   0, 1'b0, 1'b1, ST_DST_PORT, 2}
    };

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata  = 8'h00;
    logic                  s_tlast  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [23:0]           m_tdata;
    logic [0:0]            m_tuser;
    logic                  m_tlast;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr    = '0;
    logic [31:0]           pwdata   = '0;
    logic [31:0]           prdata;
    logic                  pready;

    // predictor copy of registers and packet state
    logic [7:0]  cfg_dev;
    logic [7:0]  cfg_hub;
    logic [8:0]  cfg_sport;
    int unsigned pkt_pos;
    logic [31:0] pkt_crc;
    logic [31:0] pkt_rx_crc;
    status_t     pkt_fault;
    bit          pkt_csp;

    result_t     expected_items [$];
    int          mismatches = 0;
    int          bytes_sent = 0;
    bit          no_idle    = 1'b0;

    crc32c_packet_header_checker uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic logic [31:0] crc32c_bitwise(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC32C_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Nine bits wide so that a port above 255 can never equal a byte.
    function automatic logic [8:0] dport_for(input bit csp);
        if (cfg_dev >= DEV_HIGH_LIMIT) begin
            return {1'b0, cfg_dev} - {1'b0, DPORT_HIGH_OFS};
        end
        if (csp) begin
            return {1'b0, cfg_dev} + DPORT_OFS - DPORT_CSP_ADJ;
        end
        return {1'b0, cfg_dev} + DPORT_OFS;
    endfunction

    function automatic string item_text(input result_t r);
        return $sformatf("kind %0d byte %02h status %0d len %0d last %0d",
                         r.item_kind, r.payload_byte, r.status, r.payload_length,
                         r.end_of_run);
    endfunction

    task automatic clear_packet();
        pkt_pos    = 0;
        pkt_crc    = CRC_INIT;
        pkt_rx_crc = '0;
        pkt_fault  = ST_OK;
        pkt_csp    = 1'b0;
    endtask

    // Keep the highest ranking header fault: lower code wins.
    task automatic note_fault(input status_t code);
        if (pkt_fault == ST_OK || code < pkt_fault) begin
            pkt_fault = code;
        end
    endtask

    task automatic predict_packet_byte(input logic [7:0] b, input bit last);
        int unsigned idx;
        int unsigned len;
        status_t     st;
        idx = pkt_pos;
        if (idx >= POS_LIMIT) begin
            // drop bytes beyond the longest packet, just remember the overrun
            pkt_pos = POS_LIMIT + 1;
        end else begin
            pkt_pos = idx + 1;
            if (idx == POS_HDR_TYPE) begin
                pkt_csp = (b[7:6] == TYPE_CSP);
            end else if (idx == POS_SRC_ADDR) begin
                if (b != cfg_dev) begin
                    note_fault(ST_SRC_ADDR);
                end
            end else if (idx == POS_DST_ADDR) begin
                if (b != cfg_hub) begin
                    if (b == BCAST_ADDR) begin
                        note_fault(ST_BCAST);
                    end else begin
                        note_fault(ST_DST_ADDR);
                    end
                end
            end else if (idx == POS_SRC_PORT) begin
                // a negative setting has bit 8 set and never matches
                if ({1'b0, b} != cfg_sport) begin
                    note_fault(ST_SRC_PORT);
                end
            end else if (idx == POS_DST_PORT) begin
                if ({1'b0, b} != dport_for(pkt_csp)) begin
                    note_fault(ST_DST_PORT);
                end
            end else if (idx >= POS_CRC_LO && idx <= POS_CRC_HI) begin
                pkt_rx_crc = pkt_rx_crc | (32'(b) << (8 * (idx - POS_CRC_LO)));
            end
            if ((idx >= POS_SRC_ADDR && idx <= POS_DST_PORT) || idx >= HEADER_BYTES) begin
                pkt_crc = crc32c_bitwise(pkt_crc, b);
            end
            if (idx >= HEADER_BYTES) begin
                expected_items.push_back('{KIND_PAYLOAD, b, ST_OK, LEN_W'(0), 1'b0});
            end
        end
        if (last) begin
            if (pkt_pos > POS_LIMIT) begin
                st  = ST_TOO_LONG;
                len = MAX_PAYLOAD_BYTES;
            end else if (pkt_pos < HEADER_BYTES) begin
                st  = ST_SHORT;
                len = 0;
            end else begin
                len = pkt_pos - HEADER_BYTES;
                if (pkt_fault != ST_OK) begin
                    st = pkt_fault;
                end else if (~pkt_crc != pkt_rx_crc) begin
                    st = ST_CRC;
                end else begin
                    st = ST_OK;
                end
            end
            if (len > LEN_SAT) begin
                len = LEN_SAT;
            end
            expected_items.push_back('{KIND_STATUS, 8'h00, st, LEN_W'(len), 1'b1});
            clear_packet();
        end
    endtask

    // Build a packet that fits the current registers, then break what inj asks for.
    function automatic void build_packet(input inj_e inj, input int plen, input bit csp_req,
                                         output byte_q_t pkt);
        logic [7:0]  hdr [HEADER_BYTES];
        logic [7:0]  body [$];
        logic [31:0] crc;
        logic [8:0]  dport;
        logic [1:0]  ptype;
        inj_e        hit;
        int          faults;
        int          pick;
        bit          csp;
        // force CSP where a plain type cannot reach a valid destination port
        csp = csp_req || (inj != INJ_DPORT && cfg_dev < DEV_HIGH_LIMIT &&
                          ({1'b0, cfg_dev} + DPORT_OFS) > 9'd255);
        ptype = 2'($urandom_range(0, 2));
        if (ptype == TYPE_CSP) begin
            ptype = 2'b11;
        end
        if (csp) begin
            ptype = TYPE_CSP;
        end
        dport = dport_for(csp);
        hdr[0]            = 8'($urandom);
        hdr[POS_HDR_TYPE] = {ptype, 6'($urandom)};
        hdr[POS_SRC_ADDR] = cfg_dev;
        hdr[POS_DST_ADDR] = cfg_hub;
        hdr[POS_SRC_PORT] = cfg_sport[8] ? 8'($urandom) : cfg_sport[7:0];
        hdr[POS_DST_PORT] = dport[8] ? 8'($urandom) : dport[7:0];
        faults = (inj == INJ_MULTI) ? $urandom_range(2, 3) : 1;
        for (int k = 0; k < faults; k++) begin
            if (inj == INJ_MULTI) begin
                hit = inj_e'($urandom_range(INJ_BCAST, INJ_DPORT));
            end else begin
                hit = inj;
            end
            case (hit)
                INJ_BCAST: hdr[POS_DST_ADDR] = BCAST_ADDR;
                INJ_DST:   hdr[POS_DST_ADDR] = hdr[POS_DST_ADDR] ^ 8'($urandom_range(1, 255));
                INJ_SRC:   hdr[POS_SRC_ADDR] = hdr[POS_SRC_ADDR] ^ 8'($urandom_range(1, 255));
                INJ_SPORT: hdr[POS_SRC_PORT] = hdr[POS_SRC_PORT] ^ 8'($urandom_range(1, 255));
                INJ_DPORT: hdr[POS_DST_PORT] = hdr[POS_DST_PORT] ^ 8'($urandom_range(1, 255));
                default: ;
            endcase
        end
        for (int i = 0; i < plen; i++) begin
            body.push_back(8'($urandom));
        end
        crc = CRC_INIT;
        for (int i = POS_SRC_ADDR; i <= POS_DST_PORT; i++) begin
            crc = crc32c_bitwise(crc, hdr[i]);
        end
        foreach (body[i]) begin
            crc = crc32c_bitwise(crc, body[i]);
        end
        crc = ~crc;
        for (int i = 0; i < 4; i++) begin
            hdr[POS_CRC_LO + i] = crc[8*i +: 8];
        end
        if (inj == INJ_CRC) begin
            if (plen > 0 && $urandom_range(0, 1) == 1) begin
                pick       = $urandom_range(0, plen - 1);
                body[pick] = body[pick] ^ 8'(1 << $urandom_range(0, 7));
            end else begin
                pick      = POS_CRC_LO + $urandom_range(0, 3);
                hdr[pick] = hdr[pick] ^ 8'(1 << $urandom_range(0, 7));
            end
        end
        pkt = {};
        foreach (hdr[i]) begin
            pkt.push_back(hdr[i]);
        end
        foreach (body[i]) begin
            pkt.push_back(body[i]);
        end
    endfunction

    // Hold s_tvalid high from one item to the next unless a gap is drawn.
    task automatic send_byte(input logic [7:0] b, input bit last);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        predict_packet_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_packet(input byte_q_t pkt, input int cut);
        int n;
        n = (cut > 0 && cut < pkt.size()) ? cut : pkt.size();
        for (int i = 0; i < n; i++) begin
            send_byte(pkt[i], i == n - 1);
        end
    endtask

    // Drain every expected item, then let header-only work finish.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_items.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_DEVICE_ADDRESS: cfg_dev   = value[7:0];
            REG_HUB_ADDRESS:    cfg_hub   = value[7:0];
            REG_EXPECTED_SPORT: cfg_sport = value[8:0];
            default: ;
        endcase
    endtask

    task automatic cfg_readback(input logic [1:0] idx, input logic [31:0] want,
                                input logic [31:0] mask);
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        got      = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        if ((got & mask) != want) begin
            mismatches++;
            $display("%0t: register %0d readback: expected %h, got %h",
                     $time, idx, want, got & mask);
        end
    endtask

    task automatic write_config(input logic [7:0] dev, input logic [7:0] hub,
                                input logic [8:0] sport);
        logic [31:0] junk;
        junk = $urandom;
        cfg_write(REG_DEVICE_ADDRESS, {junk[31:8], dev});
        junk = $urandom;
        cfg_write(REG_HUB_ADDRESS, {junk[31:8], hub});
        junk = $urandom;
        cfg_write(REG_EXPECTED_SPORT, {junk[31:9], sport});
        cfg_write(REG_UNUSED, $urandom);
        cfg_readback(REG_DEVICE_ADDRESS, {24'd0, dev}, 32'h0000_00FF);
        cfg_readback(REG_HUB_ADDRESS, {24'd0, hub}, 32'h0000_00FF);
        cfg_readback(REG_EXPECTED_SPORT, {23'd0, sport}, 32'h0000_01FF);
    endtask

    initial begin : result_sink
        int      gap;
        result_t got;
        result_t want;
        do @(posedge aclk); while (!aresetn);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got = '{kind_t'(m_tuser[0]), m_tdata[7:0], status_t'(m_tdata[11:8]),
                    m_tdata[20:12], m_tlast};
            if (expected_items.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected item: expected none, got %s", $time, item_text(got));
            end else begin
                want = expected_items.pop_front();
                if (got !== want) begin
                    mismatches++;
                    $display("%0t: item mismatch: expected %s, got %s",
                             $time, item_text(want), item_text(got));
                end
            end
        end
    end

    initial begin : stimulus
        byte_q_t  pkt;
        pkt_row_t row;
        int       phase;
        int       random_end;
        int       next_setting;
        int       sel;
        int       plen;
        int       n;
        logic [7:0] dev;
        logic [7:0] hub;
        logic [8:0] sport;
        cfg_dev   = 8'd0;
        cfg_hub   = 8'd0;
        cfg_sport = 9'h1FF;
        clear_packet();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        phase = 0;
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            row = DIRECTED[i];
            if (row.phase != phase) begin
                phase = row.phase;
                settle();
                case (phase)
                    1: write_config(8'd254, 8'd255, 9'd254);
                    2: write_config(8'd255, 8'd0, 9'd0);
                    default: write_config(8'd130, 8'd17, 9'd100);
                endcase
            end
            build_packet(row.inj, row.plen, row.csp, pkt);
            send_packet(pkt, row.cut);
            if (row.typed) begin
                // replace the predicted status item with the one typed in the row
                void'(expected_items.pop_back());
                expected_items.push_back('{KIND_STATUS, 8'h00, row.st, LEN_W'(row.len), 1'b1});
            end
        end

        random_end   = bytes_sent + RANDOM_BYTES;
        next_setting = bytes_sent;
        while (bytes_sent < random_end) begin
            if (bytes_sent >= next_setting) begin
                settle();
                case ($urandom_range(0, 6))
                    0: dev = 8'd0;
                    1: dev = 8'd125;
                    2: dev = 8'd126;
                    3: dev = 8'd253;
                    4: dev = 8'd254;
                    5: dev = 8'd255;
                    default: dev = 8'($urandom);
                endcase
                case ($urandom_range(0, 3))
                    0: hub = 8'd0;
                    1: hub = 8'd255;
                    2: hub = dev;
                    default: hub = 8'($urandom);
                endcase
                case ($urandom_range(0, 5))
                    0: sport = 9'h1FF;
                    1: sport = 9'd0;
                    2: sport = 9'd254;
                    3: sport = 9'($urandom_range(0, 511));
                    default: sport = 9'($urandom_range(0, 254));
                endcase
                write_config(dev, hub, sport);
                no_idle      = ($urandom_range(0, 3) == 0);
                next_setting = bytes_sent + $urandom_range(150, 400);
            end
            sel = $urandom_range(0, 99);
            if (sel < 85) begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13: plen = $urandom_range(0, 16);
                    14, 15, 16, 17, 18: plen = $urandom_range(17, 64);
                    default: plen = $urandom_range(65, MAX_PAYLOAD_BYTES);
                endcase
                if (sel < 55) begin
                    build_packet(INJ_NONE, plen, $urandom_range(0, 1), pkt);
                end else begin
                    build_packet(inj_e'($urandom_range(INJ_BCAST, INJ_MULTI)), plen,
                                 $urandom_range(0, 1), pkt);
                end
                send_packet(pkt, 0);
            end else if (sel < 92) begin
                build_packet(INJ_NONE, 0, $urandom_range(0, 1), pkt);
                send_packet(pkt, $urandom_range(1, HEADER_BYTES - 1));
            end else if (sel < 98) begin
                // raw noise, with stray last flags inside
                n = $urandom_range(1, 30);
                for (int i = 0; i < n; i++) begin
                    send_byte(8'($urandom), (i == n - 1) || ($urandom_range(0, 7) == 0));
                end
            end else if (sel < 99) begin
                build_packet(INJ_NONE, $urandom_range(MAX_PAYLOAD_BYTES + 1,
                                                      MAX_PAYLOAD_BYTES + 20),
                             $urandom_range(0, 1), pkt);
                send_packet(pkt, 0);
            end else begin
                // hold off until the block has delivered everything
                settle();
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #1_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
